### src/swm_pkg.sv
`default_nettype none
package swm_pkg;
    localparam int NumSegsDef  = 256;
    localparam int SegWordsDef = 1024;

    localparam int ActW    = 3;
    localparam int IdW     = 8;
    localparam int OffW    = 10;
    localparam int DataW   = 32;
    localparam int NwordsW = 11;
    localparam int StatW   = 3;

    typedef enum logic [ActW-1:0] {
        ACT_PROG   = 3'd0,
        ACT_MAP    = 3'd1,
        ACT_UNMAP  = 3'd2,
        ACT_STORE  = 3'd3,
        ACT_LOAD   = 3'd4,
        ACT_LDPROG = 3'd5
    } t_action;

    typedef enum logic [StatW-1:0] {
        ST_OK       = 3'd0,
        ST_BAD_ID   = 3'd1,
        ST_UNMAPPED = 3'd2,
        ST_OFFSET   = 3'd3,
        ST_NO_ROOM  = 3'd4,
        ST_SEG_ZERO = 3'd5
    } t_status;
endpackage
`default_nettype wire

### src/swm_if.sv
`default_nettype none
interface swm_in_if;
    logic                       valid;
    logic                       ready;
    logic [swm_pkg::ActW-1:0]    action;
    logic [swm_pkg::IdW-1:0]     seg_id;
    logic [swm_pkg::OffW-1:0]    offset;
    logic [swm_pkg::DataW-1:0]   value;
    logic [swm_pkg::NwordsW-1:0] num_words;
    modport source (output valid, action, seg_id, offset, value, num_words, input ready);
    modport sink   (input valid, action, seg_id, offset, value, num_words, output ready);
endinterface

interface swm_out_if;
    logic                     valid;
    logic                     ready;
    logic [swm_pkg::DataW-1:0] read_data;
    logic [swm_pkg::StatW-1:0] status;
    modport source (output valid, read_data, status, input ready);
    modport sink   (input valid, read_data, status, output ready);
endinterface
`default_nettype wire

### src/segmented_word_memory_unit.sv
`default_nettype none
// Segmented word memory: one item in, one result out. The unit handles one item at a
// time, and takes the next item only once the result has been taken. Each item passes
// through the check, execute and done states; a load that passes its checks adds a
// read state for the single-port word memory. Map walks the new segment writing zero,
// one word a cycle. Load program copies through the same port, reading and then
// writing each word. There is no clearing pass after reset: mapped flags are
// flip-flops cleared at once, a segment's length counts only while it is mapped
// (segment zero reads as empty until first mapped), and the word memory is undefined
// until written.
module segmented_word_memory_unit #(
    parameter int NUM_SEGS  = swm_pkg::NumSegsDef,
    parameter int SEG_WORDS = swm_pkg::SegWordsDef
) (
    input  wire    i_clk,
    input  wire    i_rst_n,
    swm_in_if.sink   i_in,
    swm_out_if.source o_out
);
    import swm_pkg::*;

    localparam int SegW = (NUM_SEGS > 1) ? $clog2(NUM_SEGS) : 1;
    localparam int WrdW = (SEG_WORDS > 1) ? $clog2(SEG_WORDS) : 1;
    localparam int LenW = $clog2(SEG_WORDS + 1);
    localparam int FreshW = $clog2(NUM_SEGS + 1);
    localparam int AddrW = SegW + WrdW;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_CHECK = 7'b0000010,
        S_EXEC  = 7'b0000100,
        S_CLEAR = 7'b0001000,
        S_CPRD  = 7'b0010000,
        S_CPWR  = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    t_state r_state;

    // Memories
    logic [DataW-1:0] r_words [1 << AddrW];
    logic [LenW-1:0]  r_len   [NUM_SEGS];
    logic [SegW-1:0]  r_fifo  [1 << SegW];
    logic [NUM_SEGS-1:0] r_mapped;

    logic [FreshW-1:0] r_fresh;
    logic [SegW-1:0]   r_head, r_tail;
    logic [FreshW-1:0] r_fill;

    // Item registers
    logic [ActW-1:0]    r_act;
    logic [IdW-1:0]     r_id;
    logic [OffW-1:0]    r_off;
    logic [DataW-1:0]   r_val;
    logic [NwordsW-1:0] r_nw;

    logic [LenW-1:0]  r_len_rd;   // registered length of the item's segment
    logic [LenW-1:0]  r_len0;     // length of segment zero
    logic [SegW-1:0]  r_fifo_rd;
    logic [DataW-1:0] r_word_rd;
    logic [LenW-1:0]  r_cnt;
    logic [SegW-1:0]  r_nid;
    logic [DataW-1:0] r_rdata;
    logic [StatW-1:0] r_stat;
    logic             r_ovalid;

    logic [SegW-1:0] id_s;
    logic            id_known, id_fit;
    logic [AddrW-1:0] acc_addr;
    logic            off_ok;

    assign id_fit   = ({{(32-IdW){1'b0}}, r_id} < NUM_SEGS);
    assign id_s     = SegW'(r_id) & {SegW{id_fit}};
    assign id_known = id_fit && ({{(32-IdW){1'b0}}, r_id} < 32'(r_fresh));
    assign acc_addr = {id_s, WrdW'(r_off)};
    assign off_ok   = ({{(32-OffW){1'b0}}, r_off} < 32'(r_len_rd));

    assign i_in.ready  = (r_state == S_IDLE) && !r_ovalid;
    assign o_out.valid = r_ovalid;
    assign o_out.read_data = r_rdata;
    assign o_out.status    = r_stat;

    // Table reads, registered; segment zero is empty until mapped
    always_ff @(posedge i_clk) begin
        r_len_rd  <= r_len[id_s];
        r_len0    <= r_mapped[0] ? r_len[0] : '0;
        r_fifo_rd <= r_fifo[r_head];
    end

    // Word memory single port
    logic            mem_we;
    logic [AddrW-1:0] mem_addr;
    logic [DataW-1:0] mem_wd;
    always_ff @(posedge i_clk) begin
        if (mem_we) r_words[mem_addr] <= mem_wd;
        r_word_rd <= r_words[mem_addr];
    end

    always_comb begin
        mem_we   = 1'b0;
        mem_addr = acc_addr;
        mem_wd   = r_val;
        unique case (r_state)
            S_EXEC: begin
                mem_we = (r_act == ACT_STORE) && id_known && r_mapped[id_s] && off_ok;
                if (r_act == ACT_PROG) begin
                    mem_addr = {{SegW{1'b0}}, r_len0[WrdW-1:0]};
                    mem_we   = ({{(32-LenW){1'b0}}, r_len0} < SEG_WORDS);
                end
            end
            S_CLEAR: begin
                mem_we   = 1'b1;
                mem_addr = {r_nid, r_cnt[WrdW-1:0]};
                mem_wd   = '0;
            end
            S_CPRD:  mem_addr = (r_act == ACT_LOAD) ? acc_addr : {id_s, r_cnt[WrdW-1:0]};
            S_CPWR: begin
                mem_we   = 1'b1;
                mem_addr = {{SegW{1'b0}}, r_cnt[WrdW-1:0]};
                mem_wd   = r_word_rd;
            end
            default: ;
        endcase
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_mapped <= '0;
            r_fresh  <= '0;
            r_head   <= '0;
            r_tail   <= '0;
            r_fill   <= '0;
        end else begin
            if (r_ovalid && o_out.ready) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid && i_in.ready) begin
                        r_act <= i_in.action;
                        r_id  <= i_in.seg_id;
                        r_off <= i_in.offset;
                        r_val <= i_in.value;
                        r_nw  <= i_in.num_words;
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    r_rdata <= '0;
                    r_stat  <= ST_OK;
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    case (r_act) inside
                        ACT_PROG: begin
                            r_state <= S_DONE;
                            if ({{(32-LenW){1'b0}}, r_len0} >= SEG_WORDS) begin
                                r_stat <= ST_NO_ROOM;
                            end else begin
                                r_len[0]    <= r_len0 + LenW'(1);
                                r_mapped[0] <= 1'b1;
                                if (r_fresh == '0) r_fresh <= FreshW'(1);
                            end
                        end
                        ACT_MAP: begin
                            if ({{(32-NwordsW){1'b0}}, r_nw} > SEG_WORDS) begin
                                r_stat  <= ST_NO_ROOM;
                                r_state <= S_DONE;
                            end else if (r_fill != '0) begin
                                r_nid  <= r_fifo_rd;
                                r_head <= r_head + SegW'(1);
                                r_fill <= r_fill - FreshW'(1);
                                r_cnt  <= '0;
                                r_state <= S_CLEAR;
                            end else if ((r_fresh == '0 ? 32'd1 : 32'(r_fresh)) >= NUM_SEGS) begin
                                r_stat  <= ST_NO_ROOM;
                                r_state <= S_DONE;
                            end else if (r_fresh == '0) begin
                                r_nid   <= SegW'(1);
                                r_fresh <= FreshW'(2);
                                r_cnt   <= '0;
                                r_state <= S_CLEAR;
                            end else begin
                                r_nid   <= r_fresh[SegW-1:0];
                                r_fresh <= r_fresh + FreshW'(1);
                                r_cnt   <= '0;
                                r_state <= S_CLEAR;
                            end
                        end
                        ACT_UNMAP: begin
                            r_state <= S_DONE;
                            if (r_id == '0) r_stat <= ST_SEG_ZERO;
                            else if (!id_known) r_stat <= ST_BAD_ID;
                            else if (!r_mapped[id_s]) r_stat <= ST_UNMAPPED;
                            else if (32'(r_fill) >= NUM_SEGS) r_stat <= ST_NO_ROOM;
                            else begin
                                r_fifo[r_tail]  <= id_s;
                                r_tail          <= r_tail + SegW'(1);
                                r_fill          <= r_fill + FreshW'(1);
                                r_mapped[id_s]  <= 1'b0;
                            end
                        end
                        ACT_STORE, ACT_LOAD, ACT_LDPROG: begin
                            if (!id_known) begin
                                r_stat  <= ST_BAD_ID;
                                r_state <= S_DONE;
                            end else if (!r_mapped[id_s]) begin
                                r_stat  <= ST_UNMAPPED;
                                r_state <= S_DONE;
                            end else if (!off_ok) begin
                                r_stat  <= ST_OFFSET;
                                r_state <= S_DONE;
                            end else if (r_act == ACT_LOAD) begin
                                r_state <= S_CPRD;
                            end else if (r_act == ACT_LDPROG) begin
                                r_rdata <= DataW'(r_len_rd);
                                r_cnt   <= '0;
                                r_state <= (id_s != '0) ? S_CPRD : S_DONE;
                            end else begin
                                r_state <= S_DONE;
                            end
                        end
                        default: begin
                            r_stat  <= ST_BAD_ID;
                            r_state <= S_DONE;
                        end
                    endcase
                end
                S_CLEAR: begin
                    if (r_cnt >= LenW'(r_nw)) begin
                        r_len[r_nid]    <= LenW'(r_nw);
                        r_mapped[r_nid] <= 1'b1;
                        r_rdata <= DataW'(r_nid);
                        r_state <= S_DONE;
                    end else begin
                        r_cnt <= r_cnt + LenW'(1);
                    end
                end
                S_CPRD: begin
                    // load reads here; copy alternates with S_CPWR
                    if (r_act == ACT_LOAD) begin
                        r_state <= S_DONE;
                    end else if (r_cnt >= r_len_rd) begin
                        r_len[0]    <= r_len_rd;
                        r_mapped[0] <= 1'b1;
                        r_state     <= S_DONE;
                    end else begin
                        r_state <= S_CPWR;
                    end
                end
                S_CPWR: begin
                    r_cnt   <= r_cnt + LenW'(1);
                    r_state <= S_CPRD;
                end
                S_DONE: begin
                    if (r_act == ACT_LOAD && r_stat == ST_OK) r_rdata <= r_word_rd;
                    r_ovalid <= 1'b1;
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

### sim/segmented_word_memory_unit_tb.sv
module segmented_word_memory_unit_tb;
    import swm_pkg::*;

    localparam int NSEG  = NumSegsDef;
    localparam int SWORD = SegWordsDef;
    localparam int CYCLE_LIMIT = 4000000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    swm_in_if  in_ch();
    swm_out_if out_ch();

    segmented_word_memory_unit uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    typedef struct packed {
        logic [DataW-1:0] read_data;
        logic [StatW-1:0] status;
    } t_result;

    // predictor state
    logic [DataW-1:0]   mem_words [NSEG][SWORD];
    logic [NwordsW-1:0] seg_len   [NSEG];
    bit                 seg_live  [NSEG];
    int unsigned        fresh_cnt;
    logic [IdW-1:0]     freed_ids [$];

    t_result pending_results [$];
    int unsigned n_errors = 0;
    int unsigned n_items  = 0;
    int unsigned n_results = 0;
    int unsigned cycles   = 0;
    int unsigned out_stall_max = 2;

    // clock, cycle limit
    initial begin
        forever begin
            #5 i_clk = ~i_clk;
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycles,
                     pending_results.size());
            $display("segmented_word_memory_unit_tb: FAIL");
            $finish;
        end
    end

    function automatic int gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 20);
    endfunction

    task automatic report_mismatch(input string what, input logic [DataW-1:0] got,
                                   input logic [DataW-1:0] want);
        n_errors++;
        $display("mismatch at result %0d: %s got 0x%0h expected 0x%0h",
                 n_results, what, got, want);
    endtask

    function automatic bit id_known(input logic [IdW-1:0] id);
        return int'(id) < NSEG && int'(id) < fresh_cnt;
    endfunction

    // compute the result of one item and update the predicted memory
    function automatic t_result memory_action(input logic [ActW-1:0] act,
                                              input logic [IdW-1:0] id,
                                              input logic [OffW-1:0] off,
                                              input logic [DataW-1:0] val,
                                              input logic [NwordsW-1:0] nw);
        t_result r;
        int unsigned nid;
        int unsigned nxt;
        r.read_data = '0;
        r.status = ST_OK;
        case (act)
            ACT_PROG: begin
                if (seg_len[0] >= SWORD) r.status = ST_NO_ROOM;
                else begin
                    mem_words[0][seg_len[0]] = val;
                    seg_len[0] = NwordsW'(seg_len[0] + 1);
                    seg_live[0] = 1'b1;
                    if (fresh_cnt == 0) fresh_cnt = 1;
                end
            end
            ACT_MAP: begin
                if (nw > SWORD) r.status = ST_NO_ROOM;
                else if (freed_ids.size() == 0 && ((fresh_cnt == 0 ? 1 : fresh_cnt) >= NSEG))
                    r.status = ST_NO_ROOM;
                else begin
                    if (freed_ids.size() != 0) nid = freed_ids.pop_front();
                    else begin
                        nxt = (fresh_cnt == 0) ? 1 : fresh_cnt;
                        nid = nxt;
                        fresh_cnt = nxt + 1;
                    end
                    for (int i = 0; i < nw; i++) mem_words[nid][i] = '0;
                    seg_len[nid] = nw;
                    seg_live[nid] = 1'b1;
                    r.read_data = DataW'(nid);
                end
            end
            ACT_UNMAP: begin
                if (id == 0) r.status = ST_SEG_ZERO;
                else if (!id_known(id)) r.status = ST_BAD_ID;
                else if (!seg_live[id]) r.status = ST_UNMAPPED;
                else if (freed_ids.size() >= NSEG) r.status = ST_NO_ROOM;
                else begin
                    freed_ids.push_back(id);
                    seg_live[id] = 1'b0;
                end
            end
            ACT_STORE, ACT_LOAD, ACT_LDPROG: begin
                if (!id_known(id)) r.status = ST_BAD_ID;
                else if (!seg_live[id]) r.status = ST_UNMAPPED;
                else if (off >= seg_len[id]) r.status = ST_OFFSET;
                else if (act == ACT_STORE) mem_words[id][off] = val;
                else if (act == ACT_LOAD) r.read_data = mem_words[id][off];
                else begin
                    if (id != 0) begin
                        for (int i = 0; i < seg_len[id]; i++)
                            mem_words[0][i] = mem_words[id][i];
                        seg_len[0] = seg_len[id];
                        seg_live[0] = 1'b1;
                    end
                    r.read_data = DataW'(seg_len[id]);
                end
            end
            default: r.status = ST_BAD_ID;
        endcase
        return r;
    endfunction

    // send one item, predicting its result at acceptance
    task automatic send_item(input logic [ActW-1:0] act, input logic [IdW-1:0] id,
                             input logic [OffW-1:0] off, input logic [DataW-1:0] val,
                             input logic [NwordsW-1:0] nw);
        int g;
        g = gap_len();
        if (g > 0) begin
            in_ch.valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.action    <= act;
        in_ch.seg_id    <= id;
        in_ch.offset    <= off;
        in_ch.value     <= val;
        in_ch.num_words <= nw;
        do @(posedge i_clk); while (!in_ch.ready);
        pending_results.push_back(memory_action(act, id, off, val, nw));
        n_items++;
    endtask

    // result checker with random back-pressure
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                n_results++;
                if (pending_results.size() == 0) begin
                    n_errors++;
                    $display("unexpected result data 0x%0h status %0d",
                             out_ch.read_data, out_ch.status);
                end else begin
                    want = pending_results.pop_front();
                    if (out_ch.read_data !== want.read_data)
                        report_mismatch("read_data", out_ch.read_data, want.read_data);
                    if (out_ch.status !== want.status)
                        report_mismatch("status", DataW'(out_ch.status),
                                        DataW'(want.status));
                end
            end
            out_ch.ready <= ($urandom_range(0, 9) < 7) ||
                            ($urandom_range(0, out_stall_max) == 0);
        end else begin
            out_ch.ready <= 1'b0;
        end
    end

    function automatic logic [IdW-1:0] some_id();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 8 && fresh_cnt > 0) return IdW'($urandom_range(0, fresh_cnt - 1));
        return IdW'($urandom);
    endfunction

    function automatic logic [OffW-1:0] some_off(input logic [IdW-1:0] id);
        if ($urandom_range(0, 9) < 8 && seg_len[id] > 0)
            return OffW'($urandom_range(0, seg_len[id] - 1));
        return OffW'($urandom);
    endfunction

    function automatic logic [NwordsW-1:0] map_size();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 85) return NwordsW'($urandom_range(0, 24));
        if (r < 95) return NwordsW'($urandom_range(25, SWORD));
        return NwordsW'($urandom_range(SWORD, 2047));
    endfunction

    task automatic test_directed();
        send_item(ACT_MAP, 0, 0, 0, 11'd0);           // map before any program: ID 1
        send_item(ACT_LOAD, 0, 0, 0, 0);              // segment 0 not yet mapped
        send_item(ACT_PROG, 0, 0, 32'hFFFF_FFFF, 0);
        send_item(ACT_PROG, 0, 0, 32'h0000_0000, 0);
        send_item(ACT_PROG, 0, 0, 32'h8000_0001, 0);
        send_item(ACT_LOAD, 0, 10'd2, 0, 0);
        send_item(ACT_LOAD, 0, 10'd3, 0, 0);          // offset out of range
        send_item(ACT_MAP, 0, 0, 0, 11'd1025);        // too large
        send_item(ACT_MAP, 0, 0, 0, 11'd2047);
        send_item(ACT_MAP, 0, 0, 0, 11'd4);
        send_item(ACT_STORE, 8'd2, 10'd3, 32'hA5A5_5A5A, 0);
        send_item(ACT_LOAD, 8'd2, 10'd3, 0, 0);
        send_item(ACT_LOAD, 8'd2, 10'd1, 0, 0);
        send_item(ACT_LDPROG, 8'd2, 10'd1, 0, 0);
        send_item(ACT_LDPROG, 8'd0, 10'd0, 0, 0);     // load program of segment zero
        send_item(ACT_UNMAP, 8'd0, 0, 0, 0);
        send_item(ACT_UNMAP, 8'd255, 0, 0, 0);
        send_item(ACT_UNMAP, 8'd1, 0, 0, 0);
        send_item(ACT_UNMAP, 8'd1, 0, 0, 0);          // already unmapped
        send_item(ACT_STORE, 8'd1, 0, 1, 0);
        send_item(ACT_MAP, 0, 0, 0, 11'd1024);        // reuses freed ID
        send_item(ACT_LOAD, 8'd1, 10'd1023, 0, 0);
        send_item(3'd6, 8'hFF, 10'h3FF, 32'hFFFF_FFFF, 11'h7FF);
        send_item(3'd7, 0, 0, 0, 0);
    endtask

    // fill the ID space, then exhaust it, then free some again
    task automatic test_id_exhaustion();
        while (fresh_cnt < NSEG)
            send_item(ACT_MAP, 0, 0, DataW'($urandom), NwordsW'($urandom_range(0, 3)));
        send_item(ACT_MAP, 0, 0, 0, 11'd1);
        for (int i = 0; i < 30; i++)
            send_item(ACT_UNMAP, IdW'($urandom_range(1, 255)), 0, 0, 0);
    endtask

    task automatic test_random(input int unsigned count);
        int unsigned r;
        logic [IdW-1:0] id;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            id = some_id();
            if (r < 8)
                send_item(ACT_PROG, 0, OffW'($urandom), DataW'($urandom),
                          NwordsW'($urandom));
            else if (r < 20)
                send_item(ACT_MAP, IdW'($urandom), OffW'($urandom), DataW'($urandom),
                          map_size());
            else if (r < 30)
                send_item(ACT_UNMAP, id, OffW'($urandom), DataW'($urandom),
                          NwordsW'($urandom));
            else if (r < 58)
                send_item(ACT_STORE, id, some_off(id), DataW'($urandom), NwordsW'($urandom));
            else if (r < 88)
                send_item(ACT_LOAD, id, some_off(id), DataW'($urandom), NwordsW'($urandom));
            else if (r < 96) begin
                // copy only short segments to keep the run brief
                if (seg_len[id] > 40 && $urandom_range(0, 9) != 0) id = 0;
                send_item(ACT_LDPROG, id, some_off(id), DataW'($urandom),
                          NwordsW'($urandom));
            end else
                send_item(ActW'($urandom_range(6, 7)), IdW'($urandom), OffW'($urandom),
                          DataW'($urandom), NwordsW'($urandom));
        end
    endtask

    // fill segment 0 to its end and past it
    task automatic test_program_full();
        while (seg_len[0] < SWORD) send_item(ACT_PROG, 0, 0, DataW'($urandom), 0);
        send_item(ACT_PROG, 0, 0, DataW'($urandom), 0);
        send_item(ACT_LOAD, 0, 10'd1023, 0, 0);
    endtask

    initial begin
        in_ch.valid = 1'b0;
        in_ch.action = '0;
        in_ch.seg_id = '0;
        in_ch.offset = '0;
        in_ch.value = '0;
        in_ch.num_words = '0;
        fresh_cnt = 0;
        for (int s = 0; s < NSEG; s++) begin
            seg_len[s] = '0;
            seg_live[s] = 1'b0;
        end
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random(300);
        out_stall_max = 30;
        test_id_exhaustion();
        test_random(200);
        out_stall_max = 2;
        test_program_full();
        test_random(150);
        in_ch.valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (2 * SWORD + 20) @(posedge i_clk);
        $display("sent %0d items, checked %0d results across all six actions and bad codes",
                 n_items, n_results);
        $display("covered ID reuse and exhaustion, full program segment, copies, errors: %0d",
                 n_errors);
        if (n_errors == 0 && pending_results.size() == 0) begin
            $display("segmented_word_memory_unit_tb: PASS");
        end else begin
            $display("segmented_word_memory_unit_tb: FAIL");
        end
        $finish;
    end
endmodule
